// ===== rtl/core/crcfr_pkg.sv =====
// ----------------------------------------------------------------------------
// CRC-8 frame receiver package
// Shared types, register indexes and the byte-wide CRC-8 update function.
// ----------------------------------------------------------------------------
package crcfr_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned POS_W  = 2;
	localparam int unsigned REG_IDX_W = 1;

	localparam logic [REG_IDX_W-1:0] REG_CRC_POLYNOMIAL = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_CRC_INITIAL    = 1'b1;

	localparam logic [POS_W-1:0] POS_FIRST  = 2'd0;
	localparam logic [POS_W-1:0] POS_SECOND = 2'd1;
	localparam logic [POS_W-1:0] POS_CHECK  = 2'd2;

	localparam logic [BYTE_W-1:0] POLY_RESET = 8'h07;
	localparam logic [BYTE_W-1:0] INIT_RESET = 8'h00;

	typedef logic [BYTE_W-1:0] byte_t;

	typedef struct packed {
		byte_t crc_polynomial;
		byte_t crc_initial;
	} crcfr_cfg_t;

	// One byte into an MSB-first CRC-8 without reflection.
	function automatic byte_t crc8_feed(input byte_t crc, input byte_t data,
			input byte_t poly);
		byte_t c;
		c = crc ^ data;
		for (int k = 0; k < BYTE_W; k++) begin
			if (c[BYTE_W-1]) begin
				c = {c[BYTE_W-2:0], 1'b0} ^ poly;
			end else begin
				c = {c[BYTE_W-2:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== rtl/core/crcfr_regs.sv =====
// ----------------------------------------------------------------------------
// CRC-8 frame receiver configuration registers
// APB-style register file holding the polynomial and the initial value.
// ----------------------------------------------------------------------------
module crcfr_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [2:0]                paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	output crcfr_pkg::crcfr_cfg_t     cfg
);
	import crcfr_pkg::*;

	crcfr_cfg_t              cfg_q;
	logic                    wr_en;
	logic [REG_IDX_W-1:0]    reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.crc_polynomial <= POLY_RESET;
			cfg_q.crc_initial    <= INIT_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_CRC_POLYNOMIAL: cfg_q.crc_polynomial <= pwdata[BYTE_W-1:0];
				REG_CRC_INITIAL:    cfg_q.crc_initial    <= pwdata[BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_CRC_POLYNOMIAL: prdata[BYTE_W-1:0] = cfg_q.crc_polynomial;
			REG_CRC_INITIAL:    prdata[BYTE_W-1:0] = cfg_q.crc_initial;
			default:            prdata = '0;
		endcase
	end

endmodule

// ===== rtl/core/crcfr_check.sv =====
// ----------------------------------------------------------------------------
// CRC-8 frame receiver datapath
// Frames incoming bytes, checks the CRC between the input register and the
// output register and holds each passing frame in the output register.
// ----------------------------------------------------------------------------
module crcfr_check (
	input  logic                      clk,
	input  logic                      arst_n,
	input  crcfr_pkg::crcfr_cfg_t     cfg,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [7:0]                s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [15:0]               m_tdata
);
	import crcfr_pkg::*;

	logic [POS_W-1:0] pos_q;
	byte_t            first_q;
	byte_t            second_q;

	logic  valid_s1;
	byte_t first_s1;
	byte_t second_s1;
	byte_t check_s1;

	logic  out_valid_q;
	byte_t out_first_q;
	byte_t out_second_q;

	byte_t crc_full;
	logic  match;
	logic  free_out;
	logic  free_s1;
	logic  in_acc;
	logic  frame_end;

	assign crc_full  = crc8_feed(crc8_feed(cfg.crc_initial, first_s1, cfg.crc_polynomial),
		second_s1, cfg.crc_polynomial);
	assign match     = (crc_full == check_s1);

	assign free_out  = !out_valid_q || m_tready;
	assign free_s1   = !valid_s1 || !match || free_out;
	assign frame_end = (pos_q != POS_FIRST) && (pos_q != POS_SECOND);

	assign s_tready  = !frame_end || free_s1;
	assign in_acc    = s_tvalid && s_tready;

	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {out_second_q, out_first_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= POS_FIRST;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				unique case (pos_q)
					POS_FIRST:  pos_q <= POS_SECOND;
					POS_SECOND: pos_q <= POS_CHECK;
					default:    pos_q <= POS_FIRST;
				endcase
			end
			if (free_s1) begin
				valid_s1 <= in_acc && frame_end;
			end
			if (free_out) begin
				out_valid_q <= valid_s1 && match;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && (pos_q == POS_FIRST)) begin
			first_q <= s_tdata;
		end
		if (in_acc && (pos_q == POS_SECOND)) begin
			second_q <= s_tdata;
		end
		if (free_s1 && in_acc && frame_end) begin
			first_s1  <= first_q;
			second_s1 <= second_q;
			check_s1  <= s_tdata;
		end
		if (free_out && valid_s1 && match) begin
			out_first_q  <= first_s1;
			out_second_q <= second_s1;
		end
	end

endmodule

// ===== rtl/core/crc8_checked_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// CRC-8 checked frame receiver
// Groups bytes into frames of two command bytes and a CRC-8 byte and passes
// on the command bytes of each frame whose CRC matches.
// Throughput: one byte per cycle while the output does not stall the CRC byte;
// the CRC byte's result passes through the input register and then the output register.
// Reset clears the frame position and all valid flags at once, and loads the
// polynomial with 0x07 and the initial value with 0x00.
// ----------------------------------------------------------------------------
module crc8_checked_frame_receiver (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [7:0] command_first, [15:8] command_second
);
	import crcfr_pkg::*;

	crcfr_cfg_t cfg;

	crcfr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	crcfr_check u_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// ===== tb/tb_crc8_checked_frame_receiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the CRC-8 checked frame receiver
// Streams three-byte frames into the receiver, about 65 percent of the random
// ones with a good CRC byte, the rest corrupted, and checks every command
// pair that comes out against a bit-serial CRC-8 predictor. The polynomial
// and initial value are reprogrammed over the configuration port between
// phases, each with one of four patterns of sender gaps and back-pressure.
// ----------------------------------------------------------------------------
module tb_crc8_checked_frame_receiver;
	import crcfr_pkg::*;

	localparam int unsigned CYCLE_LIMIT      = 200000;
	localparam int unsigned SETTLE_CYCLES    = 8;
	localparam int unsigned MAX_REPORTS      = 10;
	localparam int unsigned PHASES           = 8;
	localparam int unsigned FRAMES_PER_PHASE = 67;
	localparam int unsigned GOOD_FRAME_PCT   = 65;

	typedef struct packed {
		byte_t second;
		byte_t first;
	} cmd_pair_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;   // [7:0] rx_byte
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // [7:0] command_first, [15:8] command_second

	byte_t       model_poly = POLY_RESET;
	byte_t       model_init = INIT_RESET;
	logic [POS_W-1:0] frame_pos = POS_FIRST;
	byte_t       held_a = '0;
	byte_t       held_b = '0;

	byte_t       byte_queue[$];
	cmd_pair_t   pending_commands[$];
	cmd_pair_t   want;
	int unsigned bytes_queued = 0;
	int unsigned bytes_accepted = 0;
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	int unsigned sender_idle_pct = 0;
	int unsigned receiver_stall_pct = 0;

	crc8_checked_frame_receiver dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shifts the two command bytes through the CRC register one bit at a time.
	function automatic byte_t frame_crc(input byte_t first, input byte_t second);
		byte_t       crc;
		logic [15:0] bits;
		logic        fb;
		crc  = model_init;
		bits = {first, second};
		for (int i = 15; i >= 0; i--) begin
			fb  = crc[BYTE_W-1] ^ bits[i];
			crc = {crc[BYTE_W-2:0], 1'b0} ^ (fb ? model_poly : byte_t'(0));
		end
		return crc;
	endfunction

	function automatic void accept_rx_byte(input byte_t rx);
		if (frame_pos == POS_FIRST) begin
			held_a    = rx;
			frame_pos = POS_SECOND;
		end else if (frame_pos == POS_SECOND) begin
			held_b    = rx;
			frame_pos = POS_CHECK;
		end else begin
			frame_pos = POS_FIRST;
			if (frame_crc(held_a, held_b) == rx) begin
				pending_commands.push_back('{second: held_b, first: held_a});
			end
		end
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				accept_rx_byte(s_tdata);
				bytes_accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (byte_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata  <= byte_queue.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_commands.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("Unexpected command pair: first %h second %h",
							m_tdata[7:0], m_tdata[15:8]);
					end
				end else begin
					want = pending_commands.pop_front();
					if (m_tdata[7:0] !== want.first || m_tdata[15:8] !== want.second) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS) begin
							$display("Command pair mismatch: expected %h %h, got %h %h",
								want.first, want.second, m_tdata[7:0], m_tdata[15:8]);
						end
					end
				end
			end
			m_tready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input byte_t value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {24'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_CRC_POLYNOMIAL) begin
			model_poly = value;
		end else begin
			model_init = value;
		end
	endtask

	task automatic push_frame(input byte_t first, input byte_t second, input bit good);
		byte_t crc;
		crc = frame_crc(first, second);
		if (!good) begin
			crc ^= byte_t'($urandom_range(255, 1));
		end
		byte_queue.push_back(first);
		byte_queue.push_back(second);
		byte_queue.push_back(crc);
		bytes_queued += 3;
	endtask

	task automatic wait_drained();
		while (bytes_accepted != bytes_queued || pending_commands.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int unsigned idle_table[4];
		int unsigned stall_table[4];
		byte_t       poly_table[PHASES];
		byte_t       init_table[PHASES];

		idle_table  = '{0, 50, 0, 9};
		stall_table = '{0, 0, 50, 9};
		poly_table = '{POLY_RESET, 8'h00, 8'hFF, 8'h31, 8'h1D, 8'hD5, 8'h07,
			byte_t'($urandom)};
		init_table = '{INIT_RESET, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h5A,
			byte_t'($urandom), byte_t'($urandom)};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		push_frame(8'h00, 8'h00, 1'b1);
		push_frame(8'hFF, 8'hFF, 1'b1);
		push_frame(8'h00, 8'hFF, 1'b1);
		push_frame(8'hFF, 8'h00, 1'b1);
		push_frame(8'h00, 8'h00, 1'b0);
		push_frame(8'hFF, 8'hFF, 1'b0);
		push_frame(byte_t'($urandom), byte_t'($urandom), 1'b1);
		push_frame(8'h01, 8'h80, 1'b0);
		wait_drained();

		for (int p = 0; p < PHASES; p++) begin
			if (p != 0) begin
				write_reg(REG_CRC_POLYNOMIAL, poly_table[p]);
				write_reg(REG_CRC_INITIAL, init_table[p]);
			end
			sender_idle_pct    = idle_table[p % 4];
			receiver_stall_pct = stall_table[p % 4];
			for (int f = 0; f < FRAMES_PER_PHASE; f++) begin
				push_frame(byte_t'($urandom), byte_t'($urandom),
					$urandom_range(99) < GOOD_FRAME_PCT);
			end
			wait_drained();
		end

		if (mismatches == 0 && pending_commands.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
